/* rtl/pkcs1_block_parse_unit_defines.svh */
// ----------------------------------------------------------------------------
// pkcs1_block_parse_unit_defines
// Assertion macros shared by the block parser RTL.
// ----------------------------------------------------------------------------
`ifndef PKCS1_BLOCK_PARSE_UNIT_DEFINES_SVH
`define PKCS1_BLOCK_PARSE_UNIT_DEFINES_SVH

// property checked on every clock edge outside reset
`define PBP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never hold
`define PBP_ASSERT_NEVER(label, expr, msg) \
	`PBP_ASSERT(label, !(expr), msg)

`endif

/* rtl/pkcs1_bp_pkg.sv */
// ----------------------------------------------------------------------------
// pkcs1_bp_pkg
// Types and constants for the PKCS#1 v1.5 encryption block parser.
// ----------------------------------------------------------------------------
package pkcs1_bp_pkg;

	localparam int unsigned MAX_BLOCK_BYTES = 512;
	localparam int unsigned MIN_BLOCK_BYTES = 12;
	localparam int unsigned PS_MIN          = 8;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CNT_W  = 10;
	localparam int unsigned LEN_W  = 9;
	localparam int unsigned CFG_W  = 10;
	localparam int unsigned IDX_W  = 1;

	localparam logic [IDX_W-1:0] CFG_BLOCK_LEN = 1'b0;
	localparam logic [IDX_W-1:0] CFG_KEY_SIDE  = 1'b1;

	localparam logic [CFG_W-1:0] BLOCK_LEN_RST = 10'd128;

	localparam logic [1:0] BT_ZERO = 2'd0;
	localparam logic [1:0] BT_FF   = 2'd1;
	localparam logic [1:0] BT_RAND = 2'd2;

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_BT,
		PH_PAD,
		PH_DATA,
		PH_SKIP
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_LEAD,
		ST_BT_PUB,
		ST_BT_PRIV,
		ST_UNTERM,
		ST_SHORT,
		ST_NO_DATA
	} status_t;

endpackage

/* rtl/pkcs1_block_parse_unit.sv */
// ----------------------------------------------------------------------------
// pkcs1_block_parse_unit
// Strips PKCS#1 v1.5 encryption padding from a byte stream of decrypted blocks.
// ----------------------------------------------------------------------------
// One byte item is taken per cycle with no bubbles while out_ready drains the
// output register: the item sits in an input register, a compare and a counter
// update decide its result, which moves to the output register as the item
// advances. Throughput is set only by out_ready; the input side keeps accepting
// while a result waits if the output register is drained. Payload bytes come out
// as they arrive; each block closes with one item that has last set and either
// the payload length or an error status. Bytes after an error produce no item.
`include "pkcs1_block_parse_unit_defines.svh"

module pkcs1_block_parse_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [pkcs1_bp_pkg::IDX_W-1:0]         cfg_index,
	input  logic [pkcs1_bp_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [pkcs1_bp_pkg::BYTE_W-1:0]        block_byte,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [pkcs1_bp_pkg::BYTE_W-1:0]        payload_byte,
	output logic                                   is_payload,
	output logic [2:0]                             status,
	output logic [pkcs1_bp_pkg::LEN_W-1:0]         payload_len,
	output logic                                   last
);
	import pkcs1_bp_pkg::*;

	logic [CFG_W-1:0]  block_len_q;
	logic              key_side_q;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	logic [CNT_W-1:0]  pos_q;
	phase_t            phase_q;
	logic [1:0]        btype_q;
	logic [CNT_W-1:0]  pad_q;
	logic [CNT_W-1:0]  pay_q;

	logic              valid_s2;
	logic [BYTE_W-1:0] pbyte_s2;
	logic              is_pay_s2;
	status_t           status_s2;
	logic [LEN_W-1:0]  len_s2;
	logic              last_s2;

	logic              advance;
	logic [CNT_W-1:0]  eff_len;
	logic              is_last;

	phase_t            phase_mid;
	logic [1:0]        btype_mid;
	logic [CNT_W-1:0]  pad_mid;
	logic [CNT_W-1:0]  pay_mid;
	status_t           err;
	logic              emit;

	phase_t            phase_n;
	logic [1:0]        btype_n;
	logic [CNT_W-1:0]  pad_n;
	logic [CNT_W-1:0]  pay_n;
	logic [CNT_W-1:0]  pos_n;

	logic              res_valid;
	logic [BYTE_W-1:0] res_byte;
	logic              res_is_pay;
	status_t           res_status;
	logic [LEN_W-1:0]  res_len;
	logic              res_last;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_len_q <= BLOCK_LEN_RST;
			key_side_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BLOCK_LEN: block_len_q <= cfg_wdata;
				CFG_KEY_SIDE:  key_side_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// handshake
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= block_byte;
		end
	end

	// effective block length, clamped
	always_comb begin
		if (block_len_q < CFG_W'(MIN_BLOCK_BYTES)) begin
			eff_len = CNT_W'(MIN_BLOCK_BYTES);
		end else if (block_len_q > CFG_W'(MAX_BLOCK_BYTES)) begin
			eff_len = CNT_W'(MAX_BLOCK_BYTES);
		end else begin
			eff_len = block_len_q;
		end
	end

	assign is_last = ({1'b0, pos_q} + 11'd1) >= {1'b0, eff_len};

	// per-byte decode
	always_comb begin
		phase_mid = phase_q;
		btype_mid = btype_q;
		pad_mid   = pad_q;
		pay_mid   = pay_q;
		err       = ST_OK;
		emit      = 1'b0;
		case (phase_q)
			PH_LEAD: begin
				if (byte_s1 != 8'h00) err = ST_LEAD;
				else phase_mid = PH_BT;
			end
			PH_BT: begin
				if (!key_side_q) begin
					if (byte_s1[7:1] != 7'd0) err = ST_BT_PUB;
					else btype_mid = byte_s1[1:0];
				end else begin
					if (byte_s1 != 8'h02) err = ST_BT_PRIV;
					else btype_mid = BT_RAND;
				end
				pad_mid   = '0;
				pay_mid   = '0;
				phase_mid = PH_PAD;
			end
			PH_PAD: begin
				if (btype_q == BT_ZERO) begin
					if (byte_s1 == 8'h00) begin
						if (pad_q != '1) pad_mid = pad_q + CNT_W'(1);
					end else if (pad_q < CNT_W'(PS_MIN + 1)) begin
						err = ST_SHORT;
					end else begin
						emit      = 1'b1;
						pay_mid   = CNT_W'(1);
						phase_mid = PH_DATA;
					end
				end else if ((btype_q == BT_FF) ? (byte_s1 == 8'hff) : (byte_s1 != 8'h00)) begin
					if (pad_q != '1) pad_mid = pad_q + CNT_W'(1);
				end else if (byte_s1 == 8'h00) begin
					if (pad_q < CNT_W'(PS_MIN)) err = ST_SHORT;
					else if (is_last) err = ST_NO_DATA;
					else begin
						pay_mid   = '0;
						phase_mid = PH_DATA;
					end
				end else begin
					err = ST_UNTERM;
				end
			end
			PH_DATA: begin
				emit = 1'b1;
				if (pay_q != '1) pay_mid = pay_q + CNT_W'(1);
			end
			default: ;
		endcase
		if (err == ST_OK && !emit && is_last && phase_mid != PH_SKIP) begin
			if (phase_mid == PH_PAD && btype_mid == BT_ZERO && pad_mid != '0) begin
				err = (pad_mid < CNT_W'(PS_MIN + 1)) ? ST_SHORT : ST_NO_DATA;
			end else begin
				err = ST_UNTERM;
			end
		end
	end

	// next state
	always_comb begin
		if (is_last) begin
			pos_n   = '0;
			phase_n = PH_LEAD;
			btype_n = BT_ZERO;
			pad_n   = '0;
			pay_n   = '0;
		end else begin
			pos_n   = pos_q + CNT_W'(1);
			phase_n = (err != ST_OK) ? PH_SKIP : phase_mid;
			btype_n = btype_mid;
			pad_n   = pad_mid;
			pay_n   = pay_mid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= PH_LEAD;
			btype_q <= BT_ZERO;
			pad_q   <= '0;
			pay_q   <= '0;
		end else if (advance) begin
			pos_q   <= pos_n;
			phase_q <= phase_n;
			btype_q <= btype_n;
			pad_q   <= pad_n;
			pay_q   <= pay_n;
		end
	end

	// result
	always_comb begin
		res_valid  = (err != ST_OK) || emit;
		res_byte   = '0;
		res_is_pay = 1'b0;
		res_status = err;
		res_len    = '0;
		res_last   = 1'b1;
		if (err == ST_OK) begin
			res_byte   = byte_s1;
			res_is_pay = 1'b1;
			res_last   = is_last;
			if (is_last) res_len = pay_mid[CNT_W-1] ? '1 : pay_mid[LEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res_valid;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			pbyte_s2  <= res_byte;
			is_pay_s2 <= res_is_pay;
			status_s2 <= res_status;
			len_s2    <= res_len;
			last_s2   <= res_last;
		end
	end

	assign out_valid    = valid_s2;
	assign payload_byte = pbyte_s2;
	assign is_payload   = is_pay_s2;
	assign status       = status_s2;
	assign payload_len  = len_s2;
	assign last         = last_s2;

	`PBP_ASSERT(a_err_shape, out_valid && status_s2 != ST_OK |-> last_s2 && !is_pay_s2 && len_s2 == '0, "error item must be last with no payload")
	`PBP_ASSERT(a_mid_shape, out_valid && !last_s2 |-> is_pay_s2 && status_s2 == ST_OK && len_s2 == '0, "non-last item must be a payload byte")
	`PBP_ASSERT_NEVER(a_pos_range, pos_q >= CNT_W'(MAX_BLOCK_BYTES), "byte position past maximum block")
	`PBP_ASSERT(a_block_wrap, advance && is_last |=> pos_q == '0 && phase_q == PH_LEAD, "block end did not rewind parser")
	`PBP_ASSERT_NEVER(a_stall_hold, valid_s1 && valid_s2 && !out_ready && in_ready, "item taken while pipeline stalled")

endmodule

/* bench/pkcs1_block_parse_unit_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pkcs1_block_parse_unit_checker
// Watches the byte and result channels of the block parser, tracks the
// configuration writes, predicts each result of the unpadding and compares.
// ----------------------------------------------------------------------------
module pkcs1_block_parse_unit_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pkcs1_bp_pkg::IDX_W-1:0]    cfg_index,
	input  logic [pkcs1_bp_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [pkcs1_bp_pkg::BYTE_W-1:0]   block_byte,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [pkcs1_bp_pkg::BYTE_W-1:0]   payload_byte,
	input  logic                              is_payload,
	input  logic [2:0]                        status,
	input  logic [pkcs1_bp_pkg::LEN_W-1:0]    payload_len,
	input  logic                              last,
	output int                                mismatches,
	output int                                pending
);
	import pkcs1_bp_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              is_data;
		status_t           code;
		logic [LEN_W-1:0]  count;
		logic              end_flag;
	} unpad_item_t;

	logic [CFG_W-1:0] len_reg;
	logic             side_reg;
	logic [CNT_W-1:0] pos;
	phase_t           phase;
	logic [1:0]       btype;
	logic [CNT_W-1:0] pad_n;
	logic [CNT_W-1:0] data_n;
	unpad_item_t      parsed_q[$];
	unpad_item_t      seen;
	unpad_item_t      want;

	initial begin
		mismatches = 0;
		pending = 0;
	end

	function automatic int eff_len(input logic [CFG_W-1:0] k);
		if (k < MIN_BLOCK_BYTES)
			return MIN_BLOCK_BYTES;
		if (k > MAX_BLOCK_BYTES)
			return MAX_BLOCK_BYTES;
		return k;
	endfunction

	function automatic void parse_byte(input logic [BYTE_W-1:0] b);
		bit          at_end;
		bit          emit;
		bit          is_pad;
		status_t     err;
		unpad_item_t r;
		at_end = int'(pos) + 1 >= eff_len(len_reg);
		emit = 1'b0;
		err = ST_OK;
		case (phase)
			PH_LEAD: begin
				if (b != 8'h00)
					err = ST_LEAD;
				else
					phase = PH_BT;
			end
			PH_BT: begin
				if (!side_reg) begin
					if (b > 8'h01)
						err = ST_BT_PUB;
					else
						btype = b[1:0];
				end else begin
					if (b != 8'h02)
						err = ST_BT_PRIV;
					else
						btype = BT_RAND;
				end
				pad_n = '0;
				data_n = '0;
				phase = PH_PAD;
			end
			PH_PAD: begin
				if (btype == BT_ZERO) begin
					if (b == 8'h00) begin
						if (pad_n < 1023)
							pad_n = pad_n + 1;
					end else if (pad_n < PS_MIN + 1) begin
						err = ST_SHORT;
					end else begin
						emit = 1'b1;
						data_n = 1;
						phase = PH_DATA;
					end
				end else begin
					is_pad = (btype == BT_FF) ? (b == 8'hff) : (b != 8'h00);
					if (is_pad) begin
						if (pad_n < 1023)
							pad_n = pad_n + 1;
					end else if (b == 8'h00) begin
						if (pad_n < PS_MIN)
							err = ST_SHORT;
						else if (at_end)
							err = ST_NO_DATA;
						else begin
							data_n = '0;
							phase = PH_DATA;
						end
					end else begin
						err = ST_UNTERM;
					end
				end
			end
			PH_DATA: begin
				emit = 1'b1;
				if (data_n < 1023)
					data_n = data_n + 1;
			end
			default: ;
		endcase

		// block ends before the pad resolved
		if (err == ST_OK && !emit && at_end && phase != PH_SKIP) begin
			if (phase == PH_PAD && btype == BT_ZERO && pad_n >= 1)
				err = (pad_n < PS_MIN + 1) ? ST_SHORT : ST_NO_DATA;
			else
				err = ST_UNTERM;
		end

		if (err != ST_OK) begin
			r.data = '0;
			r.is_data = 1'b0;
			r.code = err;
			r.count = '0;
			r.end_flag = 1'b1;
			parsed_q.push_back(r);
			phase = PH_SKIP;
		end else if (emit) begin
			r.data = b;
			r.is_data = 1'b1;
			r.code = ST_OK;
			r.count = !at_end ? '0 : (data_n > 511) ? 9'd511 : data_n[LEN_W-1:0];
			r.end_flag = at_end;
			parsed_q.push_back(r);
		end

		if (at_end) begin
			pos = '0;
			phase = PH_LEAD;
			btype = BT_ZERO;
			pad_n = '0;
			data_n = '0;
		end else begin
			pos = pos + 1;
		end
	endfunction

	task automatic flag(input string what, input unpad_item_t exp_r, input unpad_item_t got_r);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected byte %h pay %b st %0d len %0d last %b, got byte %h pay %b st %0d len %0d last %b",
				$time, what, exp_r.data, exp_r.is_data, exp_r.code, exp_r.count, exp_r.end_flag,
				got_r.data, got_r.is_data, got_r.code, got_r.count, got_r.end_flag);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_reg = BLOCK_LEN_RST;
			side_reg = 1'b1;
			pos = '0;
			phase = PH_LEAD;
			btype = BT_ZERO;
			pad_n = '0;
			data_n = '0;
			parsed_q.delete();
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				seen.data = payload_byte;
				seen.is_data = is_payload;
				seen.code = status_t'(status);
				seen.count = payload_len;
				seen.end_flag = last;
				if (parsed_q.size() == 0) begin
					flag("unexpected item", '0, seen);
				end else begin
					want = parsed_q.pop_front();
					if (seen !== want)
						flag("wrong item", want, seen);
				end
			end
			if (in_valid && in_ready)
				parse_byte(block_byte);
			if (cfg_we) begin
				if (cfg_index == CFG_BLOCK_LEN)
					len_reg = cfg_wdata;
				else if (cfg_index == CFG_KEY_SIDE)
					side_reg = cfg_wdata[0];
			end
			pending = parsed_q.size();
		end
	end

endmodule

/* bench/pkcs1_block_parse_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pkcs1_block_parse_unit_test
// Feeds decrypted PKCS#1 v1.5 blocks to the parser: directed blocks for each
// error and corner, then random well-formed and broken blocks over several
// block lengths and key sides, with random stalls on both channels.
// ----------------------------------------------------------------------------
module pkcs1_block_parse_unit_test;
	import pkcs1_bp_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 270;
	localparam int IDLE_PCT     = 22;
	localparam int DRAIN_CYCLES = 8;

	typedef enum int {
		BLK_GOOD,
		BLK_LEAD,
		BLK_BT,
		BLK_FLIP,
		BLK_NOISE
	} blk_kind_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]   cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [BYTE_W-1:0]  block_byte = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [BYTE_W-1:0]  payload_byte;
	logic               is_payload;
	logic [2:0]         status;
	logic [LEN_W-1:0]   payload_len;
	logic               last;
	int                 mismatches;
	int                 pending;
	int                 cycles = 0;
	bit                 steady = 1'b0;
	logic [CFG_W-1:0]   len_cfg = BLOCK_LEN_RST;
	logic               side_cfg = 1'b1;
	logic [BYTE_W-1:0]  blk_bytes[$];

	pkcs1_block_parse_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.block_byte   (block_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.payload_byte (payload_byte),
		.is_payload   (is_payload),
		.status       (status),
		.payload_len  (payload_len),
		.last         (last)
	);

	pkcs1_block_parse_unit_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.block_byte   (block_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.payload_byte (payload_byte),
		.is_payload   (is_payload),
		.status       (status),
		.payload_len  (payload_len),
		.last         (last),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(negedge clk)
		out_ready = steady || ($urandom_range(99) >= IDLE_PCT);

	function automatic int eff_len(input logic [CFG_W-1:0] k);
		if (k < MIN_BLOCK_BYTES)
			return MIN_BLOCK_BYTES;
		if (k > MAX_BLOCK_BYTES)
			return MAX_BLOCK_BYTES;
		return k;
	endfunction

	function automatic logic [BYTE_W-1:0] bad_bt();
		logic [BYTE_W-1:0] v;
		if (!side_cfg)
			return $urandom_range(2, 255);
		do
			v = $urandom_range(255);
		while (v == 8'h02);
		return v;
	endfunction

	function automatic logic [BYTE_W-1:0] pad_fill(input logic [1:0] bt);
		if (bt == BT_ZERO)
			return 8'h00;
		if (bt == BT_FF)
			return 8'hff;
		return $urandom_range(1, 255);
	endfunction

	// pad counts filler bytes; for BT 0 the zeros include the separator
	task automatic make_block(input int n, input blk_kind_t kind, input logic [1:0] bt,
			input int pad);
		int flip;
		blk_bytes.delete();
		for (int i = 0; i < n; i++) begin
			if (kind == BLK_NOISE)
				blk_bytes.push_back($urandom_range(255));
			else if (i == 0)
				blk_bytes.push_back(kind == BLK_LEAD ? $urandom_range(1, 255) : 0);
			else if (i == 1)
				blk_bytes.push_back(kind == BLK_BT ? bad_bt() : bt);
			else if (i < 2 + pad)
				blk_bytes.push_back(pad_fill(bt));
			else if (i == 2 + pad && bt != BT_ZERO)
				blk_bytes.push_back(8'h00);
			else if (i == 2 + pad)
				blk_bytes.push_back($urandom_range(1, 255));
			else
				blk_bytes.push_back($urandom_range(255));
		end
		if (kind == BLK_FLIP) begin
			flip = $urandom_range(1, n - 1);
			blk_bytes[flip] = $urandom_range(255);
		end
		if (kind == BLK_NOISE && $urandom_range(1))
			blk_bytes[0] = 8'h00;
	endtask

	task automatic push_byte(input logic [BYTE_W-1:0] b);
		@(negedge clk);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		block_byte = b;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic send_bytes(input int cnt);
		repeat (cnt)
			push_byte(blk_bytes.pop_front());
	endtask

	task automatic drain_wait();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		drain_wait();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		if (idx == CFG_BLOCK_LEN)
			len_cfg = val;
		else
			side_cfg = val[0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		int               n;
		int               r;
		int               pad;
		int               rand_items;
		logic [CFG_W-1:0] len_val;
		blk_kind_t        kind;

		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset configuration: 128 byte private-key block
		make_block(128, BLK_GOOD, BT_RAND, 20);
		send_bytes(128);

		// length below range clamps to 12
		write_reg(CFG_BLOCK_LEN, 10'd0);
		make_block(12, BLK_LEAD, BT_RAND, 8);
		send_bytes(12);
		make_block(12, BLK_BT, BT_RAND, 8);
		send_bytes(12);
		make_block(12, BLK_GOOD, BT_RAND, 8);
		send_bytes(12);
		make_block(12, BLK_GOOD, BT_RAND, 9);
		send_bytes(12);
		make_block(12, BLK_GOOD, BT_RAND, 5);
		send_bytes(12);
		make_block(12, BLK_GOOD, BT_RAND, 10);
		send_bytes(12);

		write_reg(CFG_KEY_SIDE, 10'd0);
		write_reg(CFG_BLOCK_LEN, 10'd11);
		make_block(12, BLK_BT, BT_FF, 8);
		send_bytes(12);
		make_block(12, BLK_GOOD, BT_FF, 8);
		send_bytes(12);
		make_block(12, BLK_GOOD, BT_FF, 8);
		blk_bytes[4] = 8'h7e;
		send_bytes(12);
		make_block(12, BLK_GOOD, BT_ZERO, 9);
		send_bytes(12);
		make_block(12, BLK_GOOD, BT_ZERO, 4);
		send_bytes(12);
		make_block(12, BLK_GOOD, BT_ZERO, 10);
		send_bytes(12);
		make_block(12, BLK_GOOD, BT_ZERO, 8);
		send_bytes(12);

		// length shrinks mid-block, ahead of and behind the current byte
		write_reg(CFG_BLOCK_LEN, 10'd20);
		make_block(20, BLK_GOOD, BT_FF, 8);
		blk_bytes[19] = 8'hff;
		blk_bytes[18] = 8'h00;
		send_bytes(10);
		write_reg(CFG_BLOCK_LEN, 10'd12);
		send_bytes(2);
		write_reg(CFG_BLOCK_LEN, 10'd40);
		make_block(40, BLK_GOOD, BT_FF, 20);
		send_bytes(5);
		write_reg(CFG_BLOCK_LEN, 10'd12);
		send_bytes(7);
		write_reg(CFG_BLOCK_LEN, 10'd20);
		make_block(20, BLK_GOOD, BT_ZERO, 9);
		send_bytes(15);
		write_reg(CFG_BLOCK_LEN, 10'd12);
		send_bytes(1);

		// key side only counts at the BT byte
		write_reg(CFG_KEY_SIDE, 10'd1);
		make_block(12, BLK_GOOD, BT_RAND, 8);
		send_bytes(4);
		write_reg(CFG_KEY_SIDE, 10'd0);
		send_bytes(8);

		rand_items = 0;
		while (rand_items < RANDOM_ITEMS) begin
			steady = rand_items >= 80 && rand_items < 200;
			if (eff_len(len_cfg) > 64 || $urandom_range(99) < 15) begin
				r = $urandom_range(99);
				len_val = r < 12 ? $urandom_range(0, 11) : $urandom_range(12, 40);
				write_reg(CFG_BLOCK_LEN, len_val);
				if ($urandom_range(1))
					write_reg(CFG_KEY_SIDE, $urandom_range(1));
			end
			n = eff_len(len_cfg);
			r = $urandom_range(99);
			kind = r < 70 ? BLK_GOOD : r < 78 ? BLK_LEAD : r < 86 ? BLK_BT :
				r < 94 ? BLK_FLIP : BLK_NOISE;
			r = $urandom_range(99);
			pad = r < 70 ? $urandom_range(8, n - 3) : r < 80 ? $urandom_range(0, 7) :
				r < 90 ? n - 3 : n - 2;
			make_block(n, kind, side_cfg ? BT_RAND : $urandom_range(1), pad);
			send_bytes(n);
			rand_items += n;
		end
		steady = 1'b0;

		drain_wait();
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/pkcs1_bp_pkg.sv
rtl/pkcs1_block_parse_unit.sv
bench/pkcs1_block_parse_unit_checker.sv
bench/pkcs1_block_parse_unit_test.sv
